/* rtl/core/lz4d_pkg.sv */
// Shared types and constants for the LZ4 block decoder.
// Used by the output queue, the match copy engine and the top level.
package lz4d_pkg;

	// History store size and the longest run of match bytes per word in.
	localparam int OUT_BYTES = 4096;
	localparam int MAX_RUN   = 64;

	localparam int ADDR_W = $clog2(OUT_BYTES);
	localparam int POS_W  = 13;
	localparam int LEN_W  = 17;
	localparam int DIST_W = 16;
	localparam int RUN_W  = $clog2(MAX_RUN + 1);

	localparam logic [POS_W-1:0] OUT_LIMIT = POS_W'(OUT_BYTES);

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_NONE  = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE           = 3'd0,
		ERR_TRUNCATED      = 3'd1,
		ERR_LIT_OVERFLOW   = 3'd2,
		ERR_BAD_OFFSET     = 3'd3,
		ERR_MATCH_OVERFLOW = 3'd4,
		ERR_NO_FINAL_LIT   = 3'd5
	} err_t;

	// One result word as it leaves the decoder.
	typedef struct packed {
		kind_t            kind;
		logic [7:0]       out_byte;
		err_t             error_code;
		logic [POS_W-1:0] decoded_length;
		logic             more_pending;
		logic             last;
	} result_t;

	// Access request to the history RAM.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

/* rtl/core/lz4d_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package dependency. A read of the address being written returns old data.
module lz4d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; the read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/lz4d_out_q.sv */
// Two-word output queue between the decoder core and the result channel.
// Depends on lz4d_pkg for the result word type.
module lz4d_out_q import lz4d_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign out_data  = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= 2'(count_q + {1'b0, push} - {1'b0, pop});
		end
	end

	// Word storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/lz4d_copy.sv */
// Match copy engine: reads history one byte ahead, writes each byte back and emits it.
// Depends on lz4d_pkg for widths and the RAM request type.
module lz4d_copy import lz4d_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [POS_W-1:0]  start_pos,
	input  logic [DIST_W-1:0] distance,
	input  logic [RUN_W-1:0]  run,
	input  logic              space,
	input  logic [7:0]        rdata,
	output ram_req_t          ram_req,
	output logic              push,
	output logic [7:0]        push_byte,
	output logic              push_last,
	output logic              busy
);

	logic              busy_q;
	logic              rd_pend_q;
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [RUN_W-1:0]  left_q;
	logic              fwd_q;
	logic [7:0]        fwd_data_q;

	logic [7:0] data;
	logic       take;
	logic       is_last;
	logic       issue;

	// A read that hit the entry written in the same cycle takes the forwarded byte.
	assign data    = fwd_q ? fwd_data_q : rdata;
	assign take    = busy_q && rd_pend_q && space;
	assign is_last = (left_q == RUN_W'(1));
	assign issue   = busy_q && (!rd_pend_q || (take && !is_last));

	assign ram_req.we    = take;
	assign ram_req.waddr = wr_ptr_q;
	assign ram_req.wdata = data;
	assign ram_req.re    = issue;
	assign ram_req.raddr = rd_ptr_q;

	assign push      = take;
	assign push_byte = data;
	assign push_last = take && is_last;
	assign busy      = busy_q;

	// Copy control: pointers, byte count and the read-ahead flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rd_pend_q <= 1'b0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			left_q    <= '0;
			fwd_q     <= 1'b0;
		end else if (start) begin
			busy_q    <= 1'b1;
			rd_pend_q <= 1'b0;
			wr_ptr_q  <= start_pos[ADDR_W-1:0];
			rd_ptr_q  <= start_pos[ADDR_W-1:0] - distance[ADDR_W-1:0];
			left_q    <= run;
		end else begin
			if (issue) begin
				rd_ptr_q  <= rd_ptr_q + ADDR_W'(1);
				rd_pend_q <= 1'b1;
				fwd_q     <= take && (rd_ptr_q == wr_ptr_q);
			end
			if (take) begin
				wr_ptr_q <= wr_ptr_q + ADDR_W'(1);
				left_q   <= left_q - RUN_W'(1);
				if (is_last) begin
					busy_q    <= 1'b0;
					rd_pend_q <= 1'b0;
				end
			end
		end
	end

	// Byte held for forwarding.
	always_ff @(posedge clk) begin
		if (issue) begin
			fwd_data_q <= data;
		end
	end

endmodule

/* rtl/core/lz4_block_decoder.sv */
// LZ4 block decoder top level: sequence parser, history RAM, copy engine, output queue.
// Depends on lz4d_pkg, lz4d_ram, lz4d_out_q and lz4d_copy.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------------
//   in       | in_valid / in_stall     | mode, data_byte, final_byte
//   out      | out_valid / out_stall   | kind, out_byte, error_code, decoded_length,
//            |                         | more_pending, last
//   config   | cfg_wr_en               | cfg_wr_data (out_capacity)
//
// A literal that closes the block is followed by a trailing word for the done or error result.
// A match run of n bytes (n up to 64) goes through the accepting word, a read-ahead for the
// history RAM read latency, then one byte a cycle while the output queue has room, with
// write-back forwarding.
// Reset clears all control state; the history RAM has no clearing pass.
// Result words go through a two-word queue, so out_stall holds the core back only once it fills.
module lz4_block_decoder import lz4d_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             mode,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       out_byte,
	output logic [2:0]       error_code,
	output logic [POS_W-1:0] decoded_length,
	output logic             more_pending,
	output logic             last,
	input  logic             cfg_wr_en,
	input  logic [POS_W-1:0] cfg_wr_data
);

	localparam logic [3:0]       NIB_EXT   = 4'd15;
	localparam logic [7:0]       BYTE_EXT  = 8'd255;
	localparam logic [LEN_W-1:0] MIN_MATCH = LEN_W'(4);
	localparam logic [LEN_W-1:0] LEN_SAT   = '1;

	typedef enum logic [2:0] {
		PH_TOKEN, PH_LITLEN, PH_LITERAL, PH_OFFLO, PH_OFFHI, PH_MATCHLEN, PH_DRAIN
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_TAIL, ST_COPY
	} state_t;

	function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
		input logic [LEN_W-1:0] b);
		logic [LEN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LEN_W] ? LEN_SAT : s[LEN_W-1:0];
	endfunction

	// Decoder state.
	logic [POS_W-1:0]  out_pos_q;
	phase_t            phase_q;
	logic [3:0]        nib_q;
	logic [LEN_W-1:0]  lit_q;
	logic [LEN_W-1:0]  mrem_q;
	logic [DIST_W-1:0] dist_q;
	logic              disc_q;
	logic [POS_W-1:0]  out_capacity_q;

	state_t  state_q;
	result_t tail_q;
	logic    more_q;

	// Next-state values and per-word decisions.
	logic [POS_W-1:0]  pos_d;
	phase_t            phase_d;
	logic [3:0]        nib_d;
	logic [LEN_W-1:0]  lit_d;
	logic [LEN_W-1:0]  mrem_d;
	logic [DIST_W-1:0] dist_d;
	logic              disc_d;

	logic [POS_W-1:0] cap_lim;
	logic [POS_W-1:0] room;
	logic [3:0]       lit_nib;
	logic [LEN_W-1:0] len_sum;
	logic [LEN_W-1:0] match_r;
	logic [LEN_W-1:0] copy_rem;
	logic [RUN_W-1:0] run;
	logic             do_finish;
	logic             copy_go;
	logic             fail_now;
	err_t             fail_code;
	logic             soft_fail;
	logic             end_blk;
	logic             push_first;
	logic             lit_we;
	logic             tail_need;
	result_t          first_res;
	result_t          tail_res;
	logic             more_d;

	logic     accept;
	logic     q_push;
	logic     q_full;
	result_t  q_data;
	result_t  q_out;
	ram_req_t creq;
	logic     copy_push;
	logic     copy_last;
	logic     copy_busy;
	logic     copy_start;
	logic [7:0] copy_byte;
	logic [7:0] ram_rdata;
	logic       ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0] ram_wdata;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || q_full;

	// Room left below the capacity limit.
	assign cap_lim = (out_capacity_q > OUT_LIMIT) ? OUT_LIMIT : out_capacity_q;
	assign room    = (out_pos_q >= cap_lim) ? '0 : cap_lim - out_pos_q;
	assign lit_nib = data_byte[7:4];

	// Sequence parser: decide the result words and next state for one input word.
	always_comb begin
		pos_d     = out_pos_q;
		phase_d   = phase_q;
		nib_d     = nib_q;
		lit_d     = lit_q;
		mrem_d    = mrem_q;
		dist_d    = dist_q;
		disc_d    = disc_q;
		len_sum   = '0;
		match_r   = '0;
		copy_rem  = '0;
		run       = '0;
		do_finish = 1'b0;
		copy_go   = 1'b0;
		fail_now  = 1'b0;
		fail_code = ERR_NONE;
		soft_fail = 1'b0;
		end_blk   = 1'b0;
		push_first = 1'b1;
		lit_we    = 1'b0;
		tail_need = 1'b0;

		first_res = '{kind: KIND_NONE, out_byte: 8'd0, error_code: ERR_NONE,
			decoded_length: '0, more_pending: 1'b0, last: 1'b0};
		tail_res  = first_res;

		if (mode) begin
			if (phase_q == PH_DRAIN) begin
				copy_go  = 1'b1;
				copy_rem = mrem_q;
			end
		end else if (disc_q) begin
			end_blk = final_byte;
		end else begin
			case (phase_q)
				PH_TOKEN: begin
					nib_d = data_byte[3:0];
					if (lit_nib == NIB_EXT) begin
						if (final_byte) begin
							fail_now  = 1'b1;
							fail_code = ERR_TRUNCATED;
						end else begin
							lit_d   = LEN_W'(NIB_EXT);
							phase_d = PH_LITLEN;
						end
					end else if (lit_nib == 4'd0) begin
						if (final_byte) begin
							first_res.kind           = KIND_DONE;
							first_res.decoded_length = out_pos_q;
							end_blk                  = 1'b1;
						end else begin
							phase_d = PH_OFFLO;
						end
					end else if (final_byte) begin
						fail_now  = 1'b1;
						fail_code = ERR_TRUNCATED;
					end else if (POS_W'(lit_nib) > room) begin
						fail_now  = 1'b1;
						fail_code = ERR_LIT_OVERFLOW;
					end else begin
						lit_d   = LEN_W'(lit_nib);
						phase_d = PH_LITERAL;
					end
				end
				PH_LITLEN: begin
					lit_d = sat_add(lit_q, LEN_W'(data_byte));
					if (final_byte) begin
						fail_now  = 1'b1;
						fail_code = ERR_TRUNCATED;
					end else if (data_byte == BYTE_EXT) begin
						phase_d = PH_LITLEN;
					end else if (lit_d > LEN_W'(room)) begin
						fail_now  = 1'b1;
						fail_code = ERR_LIT_OVERFLOW;
					end else begin
						phase_d = PH_LITERAL;
					end
				end
				PH_LITERAL: begin
					lit_we             = 1'b1;
					pos_d              = out_pos_q + POS_W'(1);
					lit_d              = lit_q - LEN_W'(lit_q != '0);
					first_res.kind     = KIND_BYTE;
					first_res.out_byte = data_byte;
					if (lit_d == '0) begin
						if (final_byte) begin
							tail_need               = 1'b1;
							tail_res.kind           = KIND_DONE;
							tail_res.decoded_length = out_pos_q + POS_W'(1);
							end_blk                 = 1'b1;
						end else begin
							phase_d = PH_OFFLO;
						end
					end else if (final_byte) begin
						tail_need           = 1'b1;
						tail_res.kind       = KIND_ERROR;
						tail_res.error_code = ERR_TRUNCATED;
						end_blk             = 1'b1;
					end
				end
				PH_OFFLO: begin
					dist_d = DIST_W'(data_byte);
					if (final_byte) begin
						fail_now  = 1'b1;
						fail_code = ERR_TRUNCATED;
					end else begin
						phase_d = PH_OFFHI;
					end
				end
				PH_OFFHI: begin
					dist_d = {data_byte, dist_q[7:0]};
					if ((dist_d == '0) || (dist_d > DIST_W'(out_pos_q))) begin
						fail_now  = 1'b1;
						fail_code = ERR_BAD_OFFSET;
					end else if (nib_q == NIB_EXT) begin
						if (final_byte) begin
							fail_now  = 1'b1;
							fail_code = ERR_TRUNCATED;
						end else begin
							mrem_d  = LEN_W'(NIB_EXT);
							phase_d = PH_MATCHLEN;
						end
					end else begin
						do_finish = 1'b1;
						match_r   = LEN_W'(nib_q) + MIN_MATCH;
					end
				end
				PH_MATCHLEN: begin
					len_sum = sat_add(mrem_q, LEN_W'(data_byte));
					if (data_byte == BYTE_EXT) begin
						mrem_d = len_sum;
						if (final_byte) begin
							fail_now  = 1'b1;
							fail_code = ERR_TRUNCATED;
						end
					end else begin
						do_finish = 1'b1;
						match_r   = sat_add(len_sum, MIN_MATCH);
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end

		// Match complete: capacity, then block end, then copy.
		if (do_finish) begin
			mrem_d = match_r;
			if (match_r > LEN_W'(room)) begin
				fail_now  = 1'b1;
				fail_code = ERR_MATCH_OVERFLOW;
			end else if (final_byte) begin
				fail_now  = 1'b1;
				fail_code = ERR_NO_FINAL_LIT;
			end else begin
				copy_go  = 1'b1;
				copy_rem = match_r;
			end
		end

		// Hand a run of at most MAX_RUN bytes to the copy engine.
		if (copy_go) begin
			run        = (copy_rem > LEN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : copy_rem[RUN_W-1:0];
			mrem_d     = copy_rem - LEN_W'(run);
			phase_d    = (mrem_d != '0) ? PH_DRAIN : PH_TOKEN;
			pos_d      = out_pos_q + POS_W'(run);
			push_first = 1'b0;
		end

		if (fail_now) begin
			first_res.kind       = KIND_ERROR;
			first_res.error_code = fail_code;
			if (final_byte) begin
				end_blk = 1'b1;
			end else begin
				soft_fail = 1'b1;
			end
		end

		if (soft_fail) begin
			lit_d  = '0;
			mrem_d = '0;
			disc_d = 1'b1;
		end

		if (end_blk) begin
			pos_d   = '0;
			phase_d = PH_TOKEN;
			nib_d   = '0;
			lit_d   = '0;
			mrem_d  = '0;
			dist_d  = '0;
			disc_d  = 1'b0;
		end

		more_d                 = (mrem_d != '0);
		first_res.more_pending = more_d;
		first_res.last         = !tail_need;
		tail_res.more_pending  = more_d;
		tail_res.last          = 1'b1;
	end

	// Decoder state and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_pos_q      <= '0;
			phase_q        <= PH_TOKEN;
			nib_q          <= '0;
			lit_q          <= '0;
			mrem_q         <= '0;
			dist_q         <= '0;
			disc_q         <= 1'b0;
			out_capacity_q <= OUT_LIMIT;
		end else begin
			if (cfg_wr_en) begin
				out_capacity_q <= cfg_wr_data;
			end
			if (accept) begin
				out_pos_q <= pos_d;
				phase_q   <= phase_d;
				nib_q     <= nib_d;
				lit_q     <= lit_d;
				mrem_q    <= mrem_d;
				dist_q    <= dist_d;
				disc_q    <= disc_d;
			end
		end
	end

	// Sequencer: idle, trailing word after a closing literal, or match run in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tail_q  <= '0;
			more_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tail_q <= tail_res;
						more_q <= more_d;
						if (copy_go) begin
							state_q <= ST_COPY;
						end else if (tail_need) begin
							state_q <= ST_TAIL;
						end
					end
				end
				ST_TAIL: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COPY: begin
					if (copy_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output queue feed.
	assign copy_start = accept && copy_go;
	assign q_push     = (accept && push_first) || ((state_q == ST_TAIL) && !q_full) || copy_push;

	always_comb begin
		case (state_q)
			ST_TAIL: q_data = tail_q;
			ST_COPY: q_data = '{kind: KIND_BYTE, out_byte: copy_byte, error_code: ERR_NONE,
				decoded_length: '0, more_pending: more_q, last: copy_last};
			default: q_data = first_res;
		endcase
	end

	// History RAM ports: literal writes while idle, copy engine otherwise.
	assign ram_we    = (accept && lit_we) || creq.we;
	assign ram_waddr = creq.we ? creq.waddr : out_pos_q[ADDR_W-1:0];
	assign ram_wdata = creq.we ? creq.wdata : data_byte;

	lz4d_ram #(
		.WIDTH(8),
		.DEPTH(OUT_BYTES)
	) u_history (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (creq.re),
		.raddr(creq.raddr),
		.rdata(ram_rdata)
	);

	lz4d_copy u_copy (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (copy_start),
		.start_pos(out_pos_q),
		.distance (dist_d),
		.run      (run),
		.space    (!q_full),
		.rdata    (ram_rdata),
		.ram_req  (creq),
		.push     (copy_push),
		.push_byte(copy_byte),
		.push_last(copy_last),
		.busy     (copy_busy)
	);

	lz4d_out_q u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_data),
		.full     (q_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (q_out)
	);

	assign kind           = q_out.kind;
	assign out_byte       = q_out.out_byte;
	assign error_code     = q_out.error_code;
	assign decoded_length = q_out.decoded_length;
	assign more_pending   = q_out.more_pending;
	assign last           = q_out.last;

	// The queue is never written while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("output queue written while full");

	// A new run never starts while the copy engine is still busy.
	a_copy_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		copy_start |-> !copy_busy)
		else $error("copy started while busy");

	// While the sequencer waits on a run, the copy engine is at work.
	a_copy_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> copy_busy)
		else $error("copy state without an active run");

	// A pending drain always has match bytes left.
	a_drain_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DRAIN) |-> (mrem_q != '0))
		else $error("drain phase with no match bytes left");

	// The write position never passes the history size.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_pos_q <= OUT_LIMIT)
		else $error("output position beyond history size");

endmodule

/* dv/lz4_decode_checker.sv */
// Scoreboard for the LZ4 block decoder: it watches both channels and the capacity register,
// works out every result word the decoder owes and compares each one as it is accepted.
// Depends on lz4d_pkg for the result word layout, the kinds and the error codes.
module lz4_decode_checker import lz4d_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic             mode,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [1:0]       kind,
	input  logic [7:0]       out_byte,
	input  logic [2:0]       error_code,
	input  logic [POS_W-1:0] decoded_length,
	input  logic             more_pending,
	input  logic             last,
	input  logic             cfg_wr_en,
	input  logic [POS_W-1:0] cfg_wr_data,
	output int               mismatch_count,
	output int               words_owed
);

	localparam int LEN_MAX    = 131071;
	localparam int REPORT_MAX = 40;

	// Where the parser stands within the current sequence.
	typedef enum logic [2:0] {
		P_TOKEN,
		P_LITLEN,
		P_LITERAL,
		P_OFFLO,
		P_OFFHI,
		P_MATCHLEN,
		P_DRAIN
	} parse_t;

	logic [7:0]        history_mem [OUT_BYTES];
	logic [POS_W-1:0]  out_pos;
	parse_t            seq_phase;
	logic [3:0]        match_nib;
	logic [LEN_W-1:0]  lit_left;
	logic [LEN_W-1:0]  match_left;
	logic [DIST_W-1:0] match_dist;
	logic              discarding;
	logic [POS_W-1:0]  capacity;

	result_t decoded_words_due [$];
	result_t item_words [$];

	// Bytes still allowed in this block under the smaller of capacity and store size.
	function automatic int room_left();
		int lim;
		lim = (capacity > OUT_BYTES) ? OUT_BYTES : int'(capacity);
		return (int'(out_pos) >= lim) ? 0 : lim - int'(out_pos);
	endfunction

	function automatic logic [LEN_W-1:0] len_add(int a, int b);
		return (a + b > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(a + b);
	endfunction

	task automatic add_word(kind_t k, logic [7:0] b, err_t e, logic [POS_W-1:0] n);
		result_t r;
		r.kind           = k;
		r.out_byte       = b;
		r.error_code     = e;
		r.decoded_length = n;
		r.more_pending   = 1'b0;
		r.last           = 1'b0;
		item_words.push_back(r);
	endtask

	task automatic clear_sequence();
		out_pos     = '0;
		seq_phase   = P_TOKEN;
		match_nib   = '0;
		lit_left    = '0;
		match_left  = '0;
		match_dist  = '0;
		discarding  = 1'b0;
	endtask

	// An error on the final byte closes the block; otherwise the rest is thrown away.
	task automatic block_error(err_t e, bit fin);
		add_word(KIND_ERROR, 8'h00, e, '0);
		if (fin) begin
			clear_sequence();
		end else begin
			lit_left   = '0;
			match_left = '0;
			discarding = 1'b1;
		end
	endtask

	// Copy up to one run of match bytes from history, one byte at a time.
	task automatic copy_run();
		int         n;
		logic [7:0] b;
		n = 0;
		while (match_left > 0 && n < MAX_RUN) begin
			b = history_mem[ADDR_W'(out_pos - match_dist)];
			history_mem[ADDR_W'(out_pos)] = b;
			out_pos++;
			match_left--;
			add_word(KIND_BYTE, b, ERR_NONE, '0);
			n++;
		end
		seq_phase = (match_left > 0) ? P_DRAIN : P_TOKEN;
	endtask

	task automatic close_match(bit fin);
		if (match_left > room_left())
			block_error(ERR_MATCH_OVERFLOW, fin);
		else if (fin)
			block_error(ERR_NO_FINAL_LIT, 1'b1);
		else
			copy_run();
	endtask

	// Work out the result words caused by one accepted input word.
	task automatic decode_in_word(logic cont, logic [7:0] b, logic fin_l);
		int lit;
		bit fin;
		fin = (fin_l == 1'b1);
		item_words.delete();
		if (cont) begin
			if (seq_phase == P_DRAIN)
				copy_run();
			else
				add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
		end else if (discarding) begin
			add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
			if (fin)
				clear_sequence();
		end else begin
			case (seq_phase)
				P_TOKEN: begin
					lit       = int'(b[7:4]);
					match_nib = b[3:0];
					if (lit == 15) begin
						if (fin) begin
							block_error(ERR_TRUNCATED, 1'b1);
						end else begin
							lit_left  = LEN_W'(15);
							seq_phase = P_LITLEN;
							add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
						end
					end else if (lit == 0) begin
						if (fin) begin
							add_word(KIND_DONE, 8'h00, ERR_NONE, out_pos);
							clear_sequence();
						end else begin
							seq_phase = P_OFFLO;
							add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
						end
					end else if (fin) begin
						block_error(ERR_TRUNCATED, 1'b1);
					end else if (lit > room_left()) begin
						block_error(ERR_LIT_OVERFLOW, 1'b0);
					end else begin
						lit_left  = LEN_W'(lit);
						seq_phase = P_LITERAL;
						add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
					end
				end
				P_LITLEN: begin
					lit_left = len_add(int'(lit_left), int'(b));
					if (fin) begin
						block_error(ERR_TRUNCATED, 1'b1);
					end else if (b == 8'hFF) begin
						add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
					end else if (lit_left > room_left()) begin
						block_error(ERR_LIT_OVERFLOW, 1'b0);
					end else begin
						seq_phase = P_LITERAL;
						add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
					end
				end
				P_LITERAL: begin
					history_mem[ADDR_W'(out_pos)] = b;
					out_pos++;
					if (lit_left > 0)
						lit_left--;
					add_word(KIND_BYTE, b, ERR_NONE, '0);
					if (lit_left == 0) begin
						if (fin) begin
							add_word(KIND_DONE, 8'h00, ERR_NONE, out_pos);
							clear_sequence();
						end else begin
							seq_phase = P_OFFLO;
						end
					end else if (fin) begin
						block_error(ERR_TRUNCATED, 1'b1);
					end
				end
				P_OFFLO: begin
					match_dist = {8'h00, b};
					if (fin) begin
						block_error(ERR_TRUNCATED, 1'b1);
					end else begin
						seq_phase = P_OFFHI;
						add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
					end
				end
				P_OFFHI: begin
					match_dist = {b, match_dist[7:0]};
					if (match_dist == 0 || match_dist > out_pos) begin
						block_error(ERR_BAD_OFFSET, fin);
					end else if (match_nib == 4'hF) begin
						if (fin) begin
							block_error(ERR_TRUNCATED, 1'b1);
						end else begin
							match_left = LEN_W'(15);
							seq_phase  = P_MATCHLEN;
							add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
						end
					end else begin
						match_left = LEN_W'(match_nib) + LEN_W'(4);
						close_match(fin);
					end
				end
				P_MATCHLEN: begin
					match_left = len_add(int'(match_left), int'(b));
					if (b == 8'hFF) begin
						if (fin)
							block_error(ERR_TRUNCATED, 1'b1);
						else
							add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
					end else begin
						match_left = len_add(int'(match_left), 4);
						close_match(fin);
					end
				end
				default: begin
					// A compressed byte while a match is pending is ignored, final mark too.
					add_word(KIND_NONE, 8'h00, ERR_NONE, '0);
				end
			endcase
		end
		foreach (item_words[i])
			item_words[i].more_pending = (match_left != 0);
		item_words[item_words.size() - 1].last = 1'b1;
		foreach (item_words[i])
			decoded_words_due.push_back(item_words[i]);
	endtask

	task automatic compare_field(string what, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// Compare one accepted result word with the oldest one due.
	task automatic check_word();
		result_t want;
		if (decoded_words_due.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("%0t: result word expected none, got kind %0d byte %0d",
					$time, kind, out_byte);
		end else begin
			want = decoded_words_due.pop_front();
			compare_field("kind", POS_W'(want.kind), POS_W'(kind));
			compare_field("out_byte", POS_W'(want.out_byte), POS_W'(out_byte));
			compare_field("error_code", POS_W'(want.error_code), POS_W'(error_code));
			compare_field("decoded_length", want.decoded_length, decoded_length);
			compare_field("more_pending", POS_W'(want.more_pending), POS_W'(more_pending));
			compare_field("last", POS_W'(want.last), POS_W'(last));
		end
	endtask

	// Results are checked before the new input word is decoded; they cannot belong to it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_sequence();
			capacity = OUT_LIMIT;
			decoded_words_due.delete();
			mismatch_count = 0;
			words_owed <= 0;
		end else begin
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			if (out_valid && !out_stall)
				check_word();
			if (in_valid && !in_stall)
				decode_in_word(mode, data_byte, final_byte);
			words_owed <= decoded_words_due.size();
		end
	end

endmodule

/* dv/tb_top.sv */
// Top of the LZ4 block decoder testbench: clock, reset, stimulus and the verdict.
// Instantiates lz4_block_decoder and lz4_decode_checker; uses lz4d_pkg for widths.
module tb_top import lz4d_pkg::*; ();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 100;

	logic             clk;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_stall;
	logic             mode        = 1'b0;
	logic [7:0]       data_byte   = 8'h00;
	logic             final_byte  = 1'b0;
	logic             out_valid;
	logic             out_stall   = 1'b0;
	logic [1:0]       kind;
	logic [7:0]       out_byte;
	logic [2:0]       error_code;
	logic [POS_W-1:0] decoded_length;
	logic             more_pending;
	logic             last;
	logic             cfg_wr_en   = 1'b0;
	logic [POS_W-1:0] cfg_wr_data = '0;
	int               mismatch_count;
	int               words_owed;

	// One input word waiting to be offered.
	typedef struct {
		bit         cont;
		logic [7:0] data;
		bit         fin;
	} in_word_t;

	in_word_t in_words [$];

	int sender_idle  = 0;
	int stall_pct    = 0;
	int holds_asked  = 0;
	int holds_served = 0;
	int hold_left    = 0;
	int cycle_count  = 0;

	lz4_block_decoder dut (.*);

	lz4_decode_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lz4_block_decoder test failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is asked for.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			out_stall    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic put_byte(logic [7:0] b, bit fin);
		in_word_t w;
		w.cont = 1'b0;
		w.data = b;
		w.fin  = fin;
		in_words.push_back(w);
	endtask

	// Data and final mark of a continue word are ignored, so they are random.
	task automatic put_cont();
		in_word_t w;
		w.cont = 1'b1;
		w.data = 8'($urandom);
		w.fin  = 1'($urandom_range(0, 1));
		in_words.push_back(w);
	endtask

	// Length extension: 255 bytes until the remainder fits in one byte.
	task automatic put_ext(int n);
		while (n >= 255) begin
			put_byte(8'hFF, 1'b0);
			n -= 255;
		end
		put_byte(8'(n), 1'b0);
	endtask

	// A mostly well-formed block sized for the given limit, sometimes broken on purpose.
	task automatic add_block(int lim);
		int          gpos, nseq, lit, mlen, rem, first, k, lf, s;
		bit          bad, cut;
		logic [15:0] offs;
		first = in_words.size();
		gpos  = 0;
		nseq  = $urandom_range(0, 3);
		bad   = ($urandom_range(0, 9) == 0);
		cut   = ($urandom_range(0, 9) == 0);
		for (s = 0; s < nseq; s++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: lit = $urandom_range(0, 6);
				6, 7:             lit = $urandom_range(7, 14);
				default:          lit = $urandom_range(15, 30);
			endcase
			if (gpos == 0 && lit == 0)
				lit = 1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: mlen = $urandom_range(4, 18);
				6, 7:             mlen = $urandom_range(19, 70);
				8:                mlen = $urandom_range(71, 200);
				default:          mlen = $urandom_range(201, 300);
			endcase
			if (gpos + lit + mlen + 1 > lim && $urandom_range(0, 99) < 85)
				break;
			put_byte({(lit >= 15) ? 4'hF : 4'(lit), (mlen >= 19) ? 4'hF : 4'(mlen - 4)}, 1'b0);
			if (lit >= 15)
				put_ext(lit - 15);
			repeat (lit) put_byte(8'($urandom), 1'b0);
			// Short distances give overlapping copies.
			if ($urandom_range(0, 3) == 0)
				offs = 16'($urandom_range(1, (gpos + lit < 4) ? gpos + lit : 4));
			else
				offs = 16'($urandom_range(1, gpos + lit));
			if (bad && s == 0)
				offs = $urandom_range(0, 1) ? 16'd0 : 16'(gpos + lit + $urandom_range(1, 3000));
			put_byte(offs[7:0], 1'b0);
			put_byte(offs[15:8], 1'b0);
			if (mlen >= 19)
				put_ext(mlen - 19);
			if (mlen > MAX_RUN && $urandom_range(0, 7) == 0)
				put_byte(8'($urandom), 1'($urandom_range(0, 1)));
			rem = mlen - MAX_RUN;
			while (rem > 0) begin
				put_cont();
				rem -= MAX_RUN;
			end
			if ($urandom_range(0, 9) == 0)
				put_cont();
			gpos += lit + mlen;
		end
		// Closing literals-only sequence.
		lf = 0;
		if (gpos < lim)
			lf = $urandom_range(0, (lim - gpos < 6) ? lim - gpos : 6);
		if ($urandom_range(0, 9) == 0)
			lf = $urandom_range(1, 6);
		if (lf == 0) begin
			put_byte({4'h0, 4'($urandom)}, 1'b1);
		end else begin
			put_byte({4'(lf), 4'($urandom)}, 1'b0);
			for (k = 0; k < lf; k++)
				put_byte(8'($urandom), k == lf - 1);
		end
		// Truncated block: end it early on a random word.
		if (cut && in_words.size() - first > 1) begin
			k = $urandom_range(first, in_words.size() - 2);
			while (in_words.size() > k + 1)
				void'(in_words.pop_back());
			in_words[k].cont = 1'b0;
			in_words[k].fin  = 1'b1;
			put_cont();
		end
	endtask

	// Random bytes and continues, then a final byte to close whatever was started.
	task automatic add_noise();
		int n;
		n = $urandom_range(3, 10);
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				put_cont();
			else
				put_byte(8'($urandom), $urandom_range(0, 7) == 0);
		end
		put_cont();
		put_cont();
		put_byte(8'($urandom), 1'b1);
	endtask

	task automatic add_random(int n, int lim);
		while (in_words.size() < n) begin
			if ($urandom_range(0, 9) < 8)
				add_block(lim);
			else
				add_noise();
		end
	endtask

	// Offer the queued words; a stalled word is held unchanged until taken.
	task automatic send_words();
		in_word_t w;
		forever begin
			@(posedge clk);
			if (!(in_valid && in_stall)) begin
				if (in_words.size() == 0) begin
					in_valid <= 1'b0;
					break;
				end
				if ($urandom_range(0, 99) < sender_idle) begin
					in_valid <= 1'b0;
				end else begin
					w = in_words.pop_front();
					in_valid   <= 1'b1;
					mode       <= w.cont;
					data_byte  <= w.data;
					final_byte <= w.fin;
				end
			end
		end
	endtask

	// Wait for every owed word, then let any run in flight finish.
	task automatic wait_drained();
		@(posedge clk);
		while (words_owed != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(int v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= POS_W'(v);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		sender_idle = send_pct;
		stall_pct  <= recv_pct;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset capacity.
		set_idling(0, 0);
		put_byte(8'h05, 1'b1);                  // empty final literals
		put_byte(8'hF0, 1'b1);                  // extended literal count cut by the final byte
		put_byte(8'h30, 1'b1);                  // literals on a final token: truncated first
		put_byte(8'h10, 1'b0);                  // overlapping match of four from one byte
		put_byte(8'hFF, 1'b0);
		put_byte(8'h01, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h10, 1'b0);
		put_byte(8'h00, 1'b1);
		put_byte(8'h10, 1'b0);                  // zero offset, then discard to the final byte
		put_byte(8'hA5, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h12, 1'b1);
		put_byte(8'h10, 1'b0);                  // block ending in a match
		put_byte(8'h5A, 1'b0);
		put_byte(8'h01, 1'b0);
		put_byte(8'h00, 1'b1);
		put_cont();                             // continue with nothing pending
		put_byte(8'h1F, 1'b0);                  // match of 115 drained by a continue
		put_byte(8'h3C, 1'b0);
		put_byte(8'h01, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h60, 1'b0);
		put_byte(8'h77, 1'b1);                  // ignored while the match is pending
		put_cont();
		put_byte(8'h00, 1'b0);                  // offset past the output on the final byte
		put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b1);
		send_words();
		wait_drained();

		// Full capacity, no idling, with one long receiver hold-off.
		write_capacity(4096);
		set_idling(0, 0);
		holds_asked <= holds_asked + 1;
		add_random(75, 4096);
		send_words();
		wait_drained();

		write_capacity(0);
		set_idling(64, 0);
		add_random(20, 0);
		send_words();
		wait_drained();

		write_capacity(4095);
		set_idling(0, 64);
		add_random(65, 4095);
		send_words();
		wait_drained();

		write_capacity(24);
		set_idling(15, 15);
		add_random(35, 24);
		send_words();
		wait_drained();

		write_capacity(1);
		set_idling(15, 15);
		add_random(20, 1);
		send_words();
		wait_drained();

		// Extended literal and match lengths that overflow a small capacity.
		write_capacity(300);
		set_idling(0, 0);
		put_byte(8'hF0, 1'b0);
		repeat (2) put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b1);
		put_byte(8'h1F, 1'b0);
		put_byte(8'h42, 1'b0);
		put_byte(8'h01, 1'b0);
		put_byte(8'h00, 1'b0);
		repeat (2) put_byte(8'hFF, 1'b0);
		put_byte(8'h05, 1'b0);
		put_byte(8'h00, 1'b1);
		send_words();
		wait_drained();

		if (mismatch_count == 0)
			$display("lz4_block_decoder test passed");
		else
			$display("lz4_block_decoder test failed");
		$finish;
	end

endmodule
